// ===== src/ring_buffer_deque_assert.svh =====
// Assertion macros for the ring buffer deque.
`ifndef RING_BUFFER_DEQUE_ASSERT_SVH
`define RING_BUFFER_DEQUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");

// Next-cycle implication, disabled during reset.
`define RBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque assertion failed");

`endif

// ===== src/rbd_pkg.sv =====
// Package with sizes, command and status codes and index helpers for the deque.
package rbd_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int DATA_W  = 32;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 4;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic               wr_en;
      idx_type            wr_addr;
      logic [DATA_W-1:0]  wr_data;
      logic               rd_en;
      idx_type            rd_addr;
   } mem_req_type;

   function automatic idx_type idx_next(input idx_type i);
      return (i == IDX_LAST) ? '0 : i + 1'b1;
   endfunction

   function automatic idx_type idx_prev(input idx_type i);
      return (i == '0) ? IDX_LAST : i - 1'b1;
   endfunction

   function automatic idx_type idx_count(input idx_type head, input idx_type tail);
      logic [IDX_W:0] diff;
      diff = {1'b0, tail} - {1'b0, head};
      if (tail < head) begin
         diff = diff + (IDX_W+1)'(DEPTH);
      end
      return diff[IDX_W-1:0];
   endfunction

endpackage

// ===== src/rbd_store.sv =====
// Slot memory of the deque: one write port, one read port, registered read data.
module rbd_store (
   input  logic                        clock,
   input  rbd_pkg::mem_req_type        mem_req,
   output logic [rbd_pkg::DATA_W-1:0]  rd_data
);

   logic [rbd_pkg::DATA_W-1:0] mem [rbd_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data <= mem[mem_req.rd_addr];
      end
   end

endmodule

// ===== src/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: command decode, indices and result register.
//
// Usage:
//   Request channel (req_valid/req_stall, req_cmd, req_data_in) carries one command:
//   push front, push back, pop front, pop back or query. Each command yields exactly
//   one transfer on the response channel (rsp_valid/rsp_stall) with the popped word,
//   status, front and back words, count and the empty and full flags after it.
//   Pushes, queries, refused commands and pops that leave the deque empty show their
//   result in the cycle after acceptance; other pops pass through S_READ and then
//   S_OUT, since the new front or back word is fetched over the slot memory's read port.
//   One command is in flight at a time; req_stall is high until its response has
//   transferred.
//   Front and back words are cached in registers; the memory is written on pushes
//   and read once on a pop that leaves words behind.
//   Reset empties the deque (head and tail to 0) and drops any pending response;
//   slot contents are not cleared and need no clearing pass.
//   While rsp_stall is high the response holds steady and no command is accepted.
module ring_buffer_deque (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rbd_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [rbd_pkg::DATA_W-1:0]  req_data_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [rbd_pkg::DATA_W-1:0]  rsp_pop_value,
   output logic [rbd_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [rbd_pkg::DATA_W-1:0]  rsp_front_value,
   output logic signed [rbd_pkg::DATA_W-1:0]  rsp_back_value,
   output logic [rbd_pkg::COUNT_W-1:0]        rsp_count,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full
);

`include "ring_buffer_deque_assert.svh"

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   rbd_pkg::idx_type            head_ff, head_in;
   rbd_pkg::idx_type            tail_ff, tail_in;
   logic [rbd_pkg::DATA_W-1:0]  front_ff, front_in;
   logic [rbd_pkg::DATA_W-1:0]  back_ff, back_in;
   logic [rbd_pkg::DATA_W-1:0]  pop_ff, pop_in;
   logic [rbd_pkg::STAT_W-1:0]  status_ff, status_in;
   logic                        rd_back_ff, rd_back_in;

   rbd_pkg::mem_req_type        mem_req;
   logic [rbd_pkg::DATA_W-1:0]  rd_data;
   rbd_pkg::idx_type            cnt;
   logic                        empty, full, accept;

   rbd_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign empty  = (head_ff == tail_ff);
   assign full   = (rbd_pkg::idx_next(tail_ff) == head_ff);
   assign cnt    = rbd_pkg::idx_count(head_ff, tail_ff);
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      front_in   = front_ff;
      back_in    = back_ff;
      pop_in     = pop_ff;
      status_in  = status_ff;
      rd_back_in = rd_back_ff;
      mem_req    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pop_in    = '0;
               status_in = rbd_pkg::STATUS_OK;
               state_in  = S_OUT;
               case (req_cmd)
                  rbd_pkg::CMD_PUSH_FRONT: begin
                     if (empty) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = tail_ff;
                        mem_req.wr_data = req_data_in;
                        tail_in         = rbd_pkg::idx_next(tail_ff);
                        front_in        = req_data_in;
                        back_in         = req_data_in;
                     end else if (full) begin
                        status_in = rbd_pkg::STATUS_FULL;
                     end else begin
                        head_in         = rbd_pkg::idx_prev(head_ff);
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = rbd_pkg::idx_prev(head_ff);
                        mem_req.wr_data = req_data_in;
                        front_in        = req_data_in;
                     end
                  end
                  rbd_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        status_in = rbd_pkg::STATUS_FULL;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = tail_ff;
                        mem_req.wr_data = req_data_in;
                        tail_in         = rbd_pkg::idx_next(tail_ff);
                        back_in         = req_data_in;
                        if (empty) begin
                           front_in = req_data_in;
                        end
                     end
                  end
                  rbd_pkg::CMD_POP_FRONT: begin
                     if (empty) begin
                        pop_in    = '1;
                        status_in = rbd_pkg::STATUS_EMPTY;
                     end else begin
                        pop_in  = front_ff;
                        head_in = rbd_pkg::idx_next(head_ff);
                        if (rbd_pkg::idx_next(head_ff) != tail_ff) begin
                           mem_req.rd_en   = 1'b1;
                           mem_req.rd_addr = rbd_pkg::idx_next(head_ff);
                           rd_back_in      = 1'b0;
                           state_in        = S_READ;
                        end
                     end
                  end
                  rbd_pkg::CMD_POP_BACK: begin
                     if (empty) begin
                        pop_in    = '1;
                        status_in = rbd_pkg::STATUS_EMPTY;
                     end else begin
                        pop_in  = back_ff;
                        tail_in = rbd_pkg::idx_prev(tail_ff);
                        if (rbd_pkg::idx_prev(tail_ff) != head_ff) begin
                           mem_req.rd_en   = 1'b1;
                           mem_req.rd_addr = rbd_pkg::idx_prev(rbd_pkg::idx_prev(tail_ff));
                           rd_back_in      = 1'b1;
                           state_in        = S_READ;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (rd_back_ff) begin
               back_in = rd_data;
            end else begin
               front_in = rd_data;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff   <= front_in;
      back_ff    <= back_in;
      pop_ff     <= pop_in;
      status_ff  <= status_in;
      rd_back_ff <= rd_back_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_pop_value   = pop_ff;
   assign rsp_status      = status_ff;
   assign rsp_front_value = empty ? '0 : front_ff;
   assign rsp_back_value  = empty ? '0 : back_ff;
   assign rsp_count       = rbd_pkg::COUNT_W'(cnt);
   assign rsp_is_empty    = empty;
   assign rsp_is_full     = full;

   `RBD_ASSERT_NOW(a_full_refusal, clock, reset,
      rsp_valid && rsp_status == rbd_pkg::STATUS_FULL, rsp_is_full)
   `RBD_ASSERT_NOW(a_empty_refusal, clock, reset,
      rsp_valid && rsp_status == rbd_pkg::STATUS_EMPTY,
      rsp_is_empty && rsp_pop_value == -32'sd1)
   `RBD_ASSERT_NEXT(a_push_back_tail, clock, reset,
      accept && req_cmd == rbd_pkg::CMD_PUSH_BACK && !full,
      tail_ff == rbd_pkg::idx_next($past(tail_ff)) && head_ff == $past(head_ff))

endmodule
